// ----- design/sdtk_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants of the stereo delay tap with kill unit
package sdtk_pkg;

   localparam int SAMPLE_BITS    = 16;
   localparam int FIELD_BITS     = 16;
   localparam int CHAN_BITS      = 2;
   localparam int CHAN_SLOTS     = 4;
   localparam int KNOB_CHANNELS  = 3;
   localparam int GAIN_BITS      = 17;
   localparam int DELAY_BITS     = 16;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 17;

   // delay cv times scale, in samples with 11 fraction bits
   localparam int DPROD_BITS = 32;
   localparam int DCV_SHIFT  = 11;

   // gain cv: |cv| * 16 / 5 rounded, division done by reciprocal
   localparam int GAIN_CV_SHIFT = 4;
   localparam int GAIN_CV_BIAS  = 2;
   localparam int GX_BITS       = 20;
   localparam int GPROD_BITS    = 41;
   localparam int RECIP_SHIFT   = 23;
   localparam logic [20:0] GAIN_RECIP = 21'd1677722;

   // gain of 2^16 is unity
   localparam int GAIN_SHIFT = 16;
   localparam logic [GAIN_BITS-1:0]  GAIN_UNITY  = 17'd65536;
   localparam logic [GAIN_BITS-1:0]  GAIN_RESET  = 17'd32768;
   localparam logic [DELAY_BITS-1:0] DELAY_RESET = 16'd32768;
   localparam logic [DELAY_BITS-1:0] SCALE_RESET = 16'd14400;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_GAIN_ONE    = 3'd0,
      CSR_GAIN_TWO    = 3'd1,
      CSR_GAIN_THREE  = 3'd2,
      CSR_DELAY_ONE   = 3'd3,
      CSR_DELAY_TWO   = 3'd4,
      CSR_DELAY_THREE = 3'd5,
      CSR_DELAY_SCALE = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [CHAN_BITS-1:0]          channel;
      logic signed [SAMPLE_BITS-1:0] dry_left;
      logic signed [SAMPLE_BITS-1:0] dry_right;
      logic signed [SAMPLE_BITS-1:0] arrival_left;
      logic signed [SAMPLE_BITS-1:0] arrival_right;
      logic signed [FIELD_BITS-1:0]  gain_cv;
      logic signed [FIELD_BITS-1:0]  delay_cv;
      logic                          kill_button;
   } req_type;

   typedef struct packed {
      logic [CHAN_BITS-1:0]          out_channel;
      logic signed [SAMPLE_BITS-1:0] departure_left;
      logic signed [SAMPLE_BITS-1:0] departure_right;
   } rsp_type;

   // registered modulation terms handed to the setback and gain stage
   typedef struct packed {
      logic signed [DPROD_BITS-1:0] delay_prod;
      logic [GPROD_BITS-1:0]        gain_prod;
      logic                         gain_cv_neg;
      logic [DELAY_BITS-1:0]        delay_knob;
      logic [GAIN_BITS-1:0]         gain_knob;
   } mod_term_type;

endpackage

// ----- design/sdtk_mod_calc.sv -----
`timescale 1ns / 1ps
// setback and gain from knob settings and registered cv products
module sdtk_mod_calc #(
   parameter int RING_DEPTH = 65536
) (
   input  sdtk_pkg::mod_term_type                 term,
   output logic [$clog2(RING_DEPTH)-1:0]          setback,
   output logic [sdtk_pkg::GAIN_BITS-1:0]         gain
);
   import sdtk_pkg::*;

   localparam int PTR_W = $clog2(RING_DEPTH);
   localparam int SB_W  = 23;
   localparam int GR_W  = 20;
   localparam logic signed [SB_W-1:0] SB_MAX   = SB_W'(RING_DEPTH - 1);
   localparam logic signed [GR_W-1:0] GAIN_MAX = GR_W'(GAIN_UNITY);
   localparam logic [DPROD_BITS-1:0]  DCV_ROUND = DPROD_BITS'(1) << (DCV_SHIFT - 1);

   logic [DPROD_BITS-1:0] dmag;
   logic [DPROD_BITS-1:0] dround;
   logic [SB_W-1:0]       dq;
   logic signed [SB_W-1:0] sb_raw;
   logic [GAIN_BITS-1:0]  gq;
   logic signed [GR_W-1:0] g_raw;

   always_comb begin
      // delay cv term, rounded half away from zero
      dmag = term.delay_prod[DPROD_BITS-1] ? DPROD_BITS'(-term.delay_prod)
                                           : DPROD_BITS'(term.delay_prod);
      dround = dmag + DCV_ROUND;
      dq = SB_W'(dround >> DCV_SHIFT);
      sb_raw = $signed(SB_W'(term.delay_knob))
             + (term.delay_prod[DPROD_BITS-1] ? -$signed(dq) : $signed(dq));
      if (sb_raw < 0) begin
         setback = '0;
      end else if (sb_raw > SB_MAX) begin
         setback = PTR_W'(RING_DEPTH - 1);
      end else begin
         setback = sb_raw[PTR_W-1:0];
      end

      // gain cv term from the reciprocal product
      gq = term.gain_prod[RECIP_SHIFT +: GAIN_BITS];
      g_raw = $signed(GR_W'(term.gain_knob))
            + (term.gain_cv_neg ? -$signed(GR_W'(gq)) : $signed(GR_W'(gq)));
      if (g_raw < 0) begin
         gain = '0;
      end else if (g_raw > GAIN_MAX) begin
         gain = GAIN_UNITY;
      end else begin
         gain = g_raw[GAIN_BITS-1:0];
      end
   end

endmodule

// ----- design/stereo_delay_tap_with_kill_unit.sv -----
`timescale 1ns / 1ps
// top level of the three channel stereo delay tap with kill
//
// request channel (req_): one transfer per sample frame of one channel. the arrival
//   pair is stored in that channel's ring and the pair setback samples behind is
//   mixed into the dry pair. response channel (rsp_): one transfer per request.
// config channel (csr_): register writes, always ready. the user writes only while
//   the block is idle; the block itself does not enforce this.
// sequencing: one item at a time, set by the single ring memory. after the request
//   transfer one step writes the arrival pair, one reads the delayed pair, one
//   multiplies and one mixes into the output register that drives the response.
//   the next request is taken on the edge that loads the output register.
// when the receiver stalls, the finished result waits in the output register and
//   the block holds in its mix step with req_stall high until the register frees.
// reset: pointers, fill marks and kill history clear at once; knobs return to
//   their defaults. no clearing pass: each channel keeps a wrapped mark and entries
//   beyond the write pointer of a ring that has not wrapped read as zero.
// kill: a rising kill level zeroes the response and rewinds the channel's pointer
//   and wrapped mark, which empties its ring within the same item.
module stereo_delay_tap_with_kill_unit #(
   parameter int RING_DEPTH    = 65536,
   parameter int CHANNEL_COUNT = 3
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  sdtk_pkg::req_type                      req_data,
   // response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output sdtk_pkg::rsp_type                      rsp_data,
   // config write channel
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [sdtk_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [sdtk_pkg::CSR_DATA_BITS-1:0]     csr_data
);
   import sdtk_pkg::*;

   // channels that own a ring and knobs
   localparam int ACTIVE    = (CHANNEL_COUNT < KNOB_CHANNELS) ? CHANNEL_COUNT : KNOB_CHANNELS;
   localparam int PTR_W     = $clog2(RING_DEPTH);
   localparam int MEM_DEPTH = ACTIVE * RING_DEPTH;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);
   localparam int WORD_W    = 2 * SAMPLE_BITS;
   localparam int MIX_W     = SAMPLE_BITS + GAIN_BITS + 1;
   localparam int SUM_W     = SAMPLE_BITS + 2;
   localparam logic [PTR_W-1:0]       PTR_MAX     = PTR_W'(RING_DEPTH - 1);
   localparam logic [CHAN_BITS:0]     ACTIVE_CODE = (CHAN_BITS + 1)'(ACTIVE);
   localparam logic [MIX_W-1:0]       MIX_ROUND   = MIX_W'(1) << (GAIN_SHIFT - 1);
   localparam logic signed [SUM_W-1:0] SUM_HI = SUM_W'((1 << (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [SUM_W-1:0] SUM_LO = SUM_W'(-(1 << (SAMPLE_BITS - 1)));

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_ADDR = 5'b00010,
      ST_READ = 5'b00100,
      ST_MIX  = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

   // delayed product rounded half away from zero, added to dry, saturated
   function automatic logic signed [SAMPLE_BITS-1:0] mix_sample(
      input logic signed [MIX_W-1:0]       prod,
      input logic signed [SAMPLE_BITS-1:0] dry
   );
      logic [MIX_W-1:0]        mag;
      logic [MIX_W-1:0]        rnd;
      logic signed [SUM_W-1:0] wet;
      logic signed [SUM_W-1:0] sum;
      mag = prod[MIX_W-1] ? MIX_W'(-prod) : MIX_W'(prod);
      rnd = (mag + MIX_ROUND) >> GAIN_SHIFT;
      wet = prod[MIX_W-1] ? -$signed(SUM_W'(rnd)) : $signed(SUM_W'(rnd));
      sum = $signed({{(SUM_W - SAMPLE_BITS){dry[SAMPLE_BITS-1]}}, dry}) + wet;
      if (sum > SUM_HI) begin
         return SUM_HI[SAMPLE_BITS-1:0];
      end else if (sum < SUM_LO) begin
         return SUM_LO[SAMPLE_BITS-1:0];
      end
      return sum[SAMPLE_BITS-1:0];
   endfunction

   // control state
   state_type              state_ff, state_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [PTR_W-1:0]       wr_ptr_ff [CHAN_SLOTS];
   logic [PTR_W-1:0]       wr_ptr_in [CHAN_SLOTS];
   logic                   wrapped_ff [CHAN_SLOTS];
   logic                   wrapped_in [CHAN_SLOTS];
   logic                   kill_prev_ff [CHAN_SLOTS];
   logic                   kill_prev_in [CHAN_SLOTS];
   logic [GAIN_BITS-1:0]   gain_knob_ff [KNOB_CHANNELS];
   logic [GAIN_BITS-1:0]   gain_knob_in [KNOB_CHANNELS];
   logic [DELAY_BITS-1:0]  delay_knob_ff [KNOB_CHANNELS];
   logic [DELAY_BITS-1:0]  delay_knob_in [KNOB_CHANNELS];
   logic [DELAY_BITS-1:0]  scale_ff, scale_in;

   // item payload
   logic [CHAN_BITS-1:0]          ch_ff, ch_in;
   logic signed [SAMPLE_BITS-1:0] dry_l_ff, dry_l_in;
   logic signed [SAMPLE_BITS-1:0] dry_r_ff, dry_r_in;
   logic [WORD_W-1:0]             arr_word_ff, arr_word_in;
   logic                          kill_ff, kill_in;
   logic                          in_range_ff, in_range_in;
   mod_term_type                  term_ff, term_in;
   logic [GAIN_BITS-1:0]          gain_ff, gain_in;
   logic                          hit_ff, hit_in;
   logic [ADDR_W-1:0]             raddr_ff, raddr_in;
   logic signed [MIX_W-1:0]       prod_l_ff, prod_l_in;
   logic signed [MIX_W-1:0]       prod_r_ff, prod_r_in;
   rsp_type                       rsp_data_ff, rsp_data_in;

   // ring memory, left sample in the upper half
   logic [WORD_W-1:0]             ring_mem [MEM_DEPTH];
   logic [WORD_W-1:0]             rd_word_ff;
   logic                          mem_we;
   logic                          mem_re;
   logic [ADDR_W-1:0]             mem_waddr;

   // handshake and datapath helpers
   logic                          out_free;
   logic                          out_load;
   logic                          take_ready;
   logic                          req_take;
   logic                          kill_edge;
   logic [PTR_W-1:0]              cur_wp;
   logic                          cur_wrapped;
   logic [ADDR_W-1:0]             ch_base;
   logic [PTR_W-1:0]              setback;
   logic [GAIN_BITS-1:0]          gain_calc;
   logic [PTR_W-1:0]              rd_off;
   logic [FIELD_BITS-1:0]         gmag;
   logic [GX_BITS-1:0]            gx;
   logic signed [DPROD_BITS:0]    dprod_full;
   logic signed [SAMPLE_BITS-1:0] delayed_l;
   logic signed [SAMPLE_BITS-1:0] delayed_r;

   sdtk_mod_calc #(
      .RING_DEPTH (RING_DEPTH)
   ) u_mod_calc (
      .term    (term_ff),
      .setback (setback),
      .gain    (gain_calc)
   );

   // output register frees when empty or taken this cycle
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign out_load   = (state_ff == ST_OUT) && out_free;
   assign take_ready = (state_ff == ST_IDLE) || out_load;
   assign req_take   = req_valid && take_ready;
   assign req_stall  = !take_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign csr_ready  = 1'b1;

   assign cur_wp      = wr_ptr_ff[ch_ff];
   assign cur_wrapped = wrapped_ff[ch_ff];
   assign ch_base     = ADDR_W'(ch_ff) * ADDR_W'(RING_DEPTH);
   assign kill_edge   = in_range_ff && kill_ff && !kill_prev_ff[ch_ff];

   // arrival pair goes in during the address step and the read comes in the read step
   // after it, so a zero setback sees the fresh pair without forwarding
   assign mem_we    = (state_ff == ST_ADDR) && in_range_ff;
   assign mem_re    = (state_ff == ST_READ);
   assign mem_waddr = ch_base + ADDR_W'(cur_wp);

   always_comb begin
      rd_off = (cur_wp >= setback)
             ? (cur_wp - setback)
             : PTR_W'((PTR_W + 1)'(cur_wp) + (PTR_W + 1)'(RING_DEPTH)
                      - (PTR_W + 1)'(setback));
   end

   // request side cv products
   always_comb begin
      gmag = req_data.gain_cv[FIELD_BITS-1] ? FIELD_BITS'(-req_data.gain_cv)
                                            : FIELD_BITS'(req_data.gain_cv);
      gx = (GX_BITS'(gmag) << GAIN_CV_SHIFT) + GX_BITS'(GAIN_CV_BIAS);
      dprod_full = $signed({{(DPROD_BITS + 1 - FIELD_BITS){req_data.delay_cv[FIELD_BITS-1]}},
                            req_data.delay_cv})
                 * $signed({{(DPROD_BITS + 1 - DELAY_BITS){1'b0}}, scale_ff});
   end

   always_comb begin
      delayed_l = hit_ff ? $signed(rd_word_ff[WORD_W-1:SAMPLE_BITS]) : '0;
      delayed_r = hit_ff ? $signed(rd_word_ff[SAMPLE_BITS-1:0]) : '0;
   end

   // next state of sequencer, payload and per channel marks
   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      wr_ptr_in     = wr_ptr_ff;
      wrapped_in    = wrapped_ff;
      kill_prev_in  = kill_prev_ff;
      gain_knob_in  = gain_knob_ff;
      delay_knob_in = delay_knob_ff;
      scale_in      = scale_ff;

      ch_in       = ch_ff;
      dry_l_in    = dry_l_ff;
      dry_r_in    = dry_r_ff;
      arr_word_in = arr_word_ff;
      kill_in     = kill_ff;
      in_range_in = in_range_ff;
      term_in     = term_ff;
      gain_in     = gain_ff;
      hit_in      = hit_ff;
      raddr_in    = raddr_ff;
      prod_l_in   = prod_l_ff;
      prod_r_in   = prod_r_ff;
      rsp_data_in = rsp_data_ff;

      // config writes
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_GAIN_ONE:    gain_knob_in[0]  = csr_data;
            CSR_GAIN_TWO:    gain_knob_in[1]  = csr_data;
            CSR_GAIN_THREE:  gain_knob_in[2]  = csr_data;
            CSR_DELAY_ONE:   delay_knob_in[0] = csr_data[DELAY_BITS-1:0];
            CSR_DELAY_TWO:   delay_knob_in[1] = csr_data[DELAY_BITS-1:0];
            CSR_DELAY_THREE: delay_knob_in[2] = csr_data[DELAY_BITS-1:0];
            CSR_DELAY_SCALE: scale_in         = csr_data[DELAY_BITS-1:0];
            default: ;
         endcase
      end

      // capture a new item
      if (req_take) begin
         ch_in       = req_data.channel;
         dry_l_in    = req_data.dry_left;
         dry_r_in    = req_data.dry_right;
         arr_word_in = {req_data.arrival_left, req_data.arrival_right};
         kill_in     = req_data.kill_button;
         in_range_in = {1'b0, req_data.channel} < ACTIVE_CODE;
         term_in.delay_prod  = dprod_full[DPROD_BITS-1:0];
         term_in.gain_prod   = GPROD_BITS'(gx) * GPROD_BITS'(GAIN_RECIP);
         term_in.gain_cv_neg = req_data.gain_cv[FIELD_BITS-1];
         term_in.delay_knob  = '0;
         term_in.gain_knob   = '0;
         if ({1'b0, req_data.channel} < (CHAN_BITS + 1)'(KNOB_CHANNELS)) begin
            term_in.delay_knob = delay_knob_ff[req_data.channel];
            term_in.gain_knob  = gain_knob_ff[req_data.channel];
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_ADDR;
            end
         end
         ST_ADDR: begin
            gain_in  = gain_calc;
            hit_in   = cur_wrapped || (setback <= cur_wp);
            raddr_in = in_range_ff ? (ch_base + ADDR_W'(rd_off)) : '0;
            state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_MIX;
         end
         ST_MIX: begin
            prod_l_in = $signed({{(MIX_W - SAMPLE_BITS){delayed_l[SAMPLE_BITS-1]}}, delayed_l})
                      * $signed({{(MIX_W - GAIN_BITS){1'b0}}, gain_ff});
            prod_r_in = $signed({{(MIX_W - SAMPLE_BITS){delayed_r[SAMPLE_BITS-1]}}, delayed_r})
                      * $signed({{(MIX_W - GAIN_BITS){1'b0}}, gain_ff});
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.out_channel     = ch_ff;
               rsp_data_in.departure_left  = '0;
               rsp_data_in.departure_right = '0;
               if (in_range_ff && !kill_edge) begin
                  rsp_data_in.departure_left  = mix_sample(prod_l_ff, dry_l_ff);
                  rsp_data_in.departure_right = mix_sample(prod_r_ff, dry_r_ff);
               end
               if (in_range_ff) begin
                  kill_prev_in[ch_ff] = kill_ff;
                  if (kill_edge) begin
                     // rewinding the pointer empties the ring
                     wr_ptr_in[ch_ff]  = '0;
                     wrapped_in[ch_ff] = 1'b0;
                  end else if (cur_wp == PTR_MAX) begin
                     wr_ptr_in[ch_ff]  = '0;
                     wrapped_in[ch_ff] = 1'b1;
                  end else begin
                     wr_ptr_in[ch_ff] = cur_wp + PTR_W'(1);
                  end
               end
               state_in = req_take ? ST_ADDR : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         scale_ff     <= SCALE_RESET;
         for (int i = 0; i < CHAN_SLOTS; i++) begin
            wr_ptr_ff[i]    <= '0;
            wrapped_ff[i]   <= 1'b0;
            kill_prev_ff[i] <= 1'b0;
         end
         for (int i = 0; i < KNOB_CHANNELS; i++) begin
            gain_knob_ff[i]  <= GAIN_RESET;
            delay_knob_ff[i] <= DELAY_RESET;
         end
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         scale_ff      <= scale_in;
         wr_ptr_ff     <= wr_ptr_in;
         wrapped_ff    <= wrapped_in;
         kill_prev_ff  <= kill_prev_in;
         gain_knob_ff  <= gain_knob_in;
         delay_knob_ff <= delay_knob_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ch_ff       <= ch_in;
      dry_l_ff    <= dry_l_in;
      dry_r_ff    <= dry_r_in;
      arr_word_ff <= arr_word_in;
      kill_ff     <= kill_in;
      in_range_ff <= in_range_in;
      term_ff     <= term_in;
      gain_ff     <= gain_in;
      hit_ff      <= hit_in;
      raddr_ff    <= raddr_in;
      prod_l_ff   <= prod_l_in;
      prod_r_ff   <= prod_r_in;
      rsp_data_ff <= rsp_data_in;
   end

   // ring memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[mem_waddr] <= arr_word_ff;
      end
      if (mem_re) begin
         rd_word_ff <= ring_mem[raddr_ff];
      end
   end

`ifndef SYNTHESIS
   // an item that writes its ring passes the read and multiply steps to the mix step
   assert property (@(posedge clock) disable iff (reset)
      mem_we |-> ##3 (state_ff == ST_OUT))
      else $error("ring write not followed by mix step");

   // a kill edge always leaves a silent response
   assert property (@(posedge clock) disable iff (reset)
      (out_load && kill_edge) |=> (rsp_valid && rsp_data.departure_left == '0
                                   && rsp_data.departure_right == '0))
      else $error("kill response not silent");

   // first channel pointer stays inside its ring
   assert property (@(posedge clock) disable iff (reset)
      wr_ptr_ff[0] <= PTR_MAX)
      else $error("write pointer out of ring");
`endif

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the stereo delay tap with kill unit
module tb;
   import sdtk_pkg::*;

   // block sizes as instantiated
   localparam int RING_DEPTH = 65536;
   localparam int CHANNELS   = KNOB_CHANNELS;
   // response delay after the request transfer, used to pad the settle wait
   localparam int LATENCY    = 4;
   // cycles without any transfer before the run is declared hung
   localparam int WATCHDOG_LIMIT  = 3000;
   // length of the long receiver hold-off that backs the block up
   localparam int HOLD_OFF_CYCLES = 300;
   localparam longint SAMPLE_MAX = 32767;
   localparam longint SAMPLE_MIN = -32768;
   // register index that decodes to nothing
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED = 3'd7;

   typedef enum int {KNOBS_SHORT, KNOBS_FLOOR, KNOBS_CEILING} knob_style_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data  = '0;

   // shadow of the block: knobs, rings, pointers, kill history
   logic [GAIN_BITS-1:0]  gain_knob [CHANNELS];
   logic [DELAY_BITS-1:0] delay_knob [CHANNELS];
   logic [DELAY_BITS-1:0] cv_scale;
   logic signed [SAMPLE_BITS-1:0] ring_left  [CHANNELS][RING_DEPTH];
   logic signed [SAMPLE_BITS-1:0] ring_right [CHANNELS][RING_DEPTH];
   int unsigned wr_ptr [CHANNELS];
   // set once the pointer has gone all the way round since reset or kill;
   // until then entries past the pointer hold nothing and read as zero
   bit ring_wrapped [CHANNELS];
   bit kill_prev [CHANNELS];

   // mixed pairs waiting for their response transfer
   rsp_type expected_mix [$];
   rsp_type oldest_mix;
   int error_count = 0;

   // traffic shaping shared between the sender and the receiver
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int hold_off_requests = 0;
   int hold_off_served = 0;
   int hold_off_left = 0;
   int quiet_cycles = 0;
   // kill level per channel slot for the random traffic
   bit kill_level [CHAN_SLOTS];

   stereo_delay_tap_with_kill_unit #(
      .RING_DEPTH    (RING_DEPTH),
      .CHANNEL_COUNT (CHANNELS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // arithmetic of the mix
   // ---------------------------------------------------------------------

   // n / 2^sh, ties away from zero
   function automatic longint round_half_away(input longint n, input int sh);
      longint mag;
      longint q;
      mag = (n < 0) ? -n : n;
      q = (mag + (longint'(1) << (sh - 1))) >>> sh;
      return (n < 0) ? -q : q;
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] saturate(input longint x);
      if (x > SAMPLE_MAX) return 16'h7FFF;
      if (x < SAMPLE_MIN) return 16'h8000;
      return 16'(x);
   endfunction

   // one frame through the shadow: store the arrival pair, tap the ring,
   // mix, advance the pointer, then apply a kill edge
   function automatic rsp_type mix_frame(input req_type f);
      rsp_type r;
      int unsigned k;
      int unsigned wp;
      int unsigned rd;
      longint setback;
      longint gcv;
      longint q;
      longint gain;
      longint tap_l;
      longint tap_r;
      logic [SAMPLE_BITS-1:0] mix_l;
      logic [SAMPLE_BITS-1:0] mix_r;
      r.out_channel = f.channel;
      r.departure_left = '0;
      r.departure_right = '0;
      // spare channel slot: zeros out, nothing stored
      if (f.channel >= CHANNELS) return r;
      k = f.channel;
      wp = wr_ptr[k];
      ring_left[k][wp] = f.arrival_left;
      ring_right[k][wp] = f.arrival_right;

      setback = longint'(delay_knob[k])
              + round_half_away(longint'($signed(f.delay_cv)) * longint'(cv_scale), DCV_SHIFT);
      if (setback < 0) setback = 0;
      else if (setback > RING_DEPTH - 1) setback = RING_DEPTH - 1;

      // ten volts of gain cv add unity: |cv| * 16 / 5 gain units
      gcv = longint'($signed(f.gain_cv));
      q = ((((gcv < 0) ? -gcv : gcv) << GAIN_CV_SHIFT) + GAIN_CV_BIAS) / 5;
      gain = longint'(gain_knob[k]) + ((gcv < 0) ? -q : q);
      if (gain < 0) gain = 0;
      else if (gain > longint'(GAIN_UNITY)) gain = longint'(GAIN_UNITY);

      rd = int'((longint'(wp) + RING_DEPTH - setback) % RING_DEPTH);
      if (ring_wrapped[k] || rd <= wp) begin
         tap_l = ring_left[k][rd];
         tap_r = ring_right[k][rd];
      end else begin
         tap_l = 0;
         tap_r = 0;
      end
      mix_l = saturate(longint'($signed(f.dry_left)) + round_half_away(tap_l * gain, GAIN_SHIFT));
      mix_r = saturate(longint'($signed(f.dry_right)) + round_half_away(tap_r * gain, GAIN_SHIFT));

      if (wp == RING_DEPTH - 1) begin
         wr_ptr[k] = 0;
         ring_wrapped[k] = 1'b1;
      end else begin
         wr_ptr[k] = wp + 1;
      end

      // only the rising kill level clears; a held button passes audio
      if (f.kill_button && !kill_prev[k]) begin
         mix_l = '0;
         mix_r = '0;
         wr_ptr[k] = 0;
         ring_wrapped[k] = 1'b0;
      end
      kill_prev[k] = f.kill_button;

      r.departure_left = mix_l;
      r.departure_right = mix_r;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------

   function automatic req_type make_frame(input logic [CHAN_BITS-1:0] ch,
                                          input logic [15:0] dl, input logic [15:0] dr,
                                          input logic [15:0] al, input logic [15:0] ar,
                                          input logic [15:0] gcv, input logic [15:0] dcv,
                                          input logic kill);
      req_type f;
      f.channel = ch;
      f.dry_left = dl;
      f.dry_right = dr;
      f.arrival_left = al;
      f.arrival_right = ar;
      f.gain_cv = gcv;
      f.delay_cv = dcv;
      f.kill_button = kill;
      return f;
   endfunction

   // full-scale samples show up often to hit saturation
   function automatic logic [15:0] pick_sample();
      case ($urandom_range(9))
         0: return 16'h7FFF;
         1: return 16'h8000;
         default: return 16'($urandom);
      endcase
   endfunction

   // modulation: mostly small swings around zero, some rails and noise
   function automatic logic [15:0] pick_cv(input int unsigned span);
      case ($urandom_range(9))
         0, 1: return '0;
         2: return 16'h7FFF;
         3: return 16'h8000;
         4, 5: return 16'($urandom);
         default: return 16'($urandom_range(2 * span) - span);
      endcase
   endfunction

   // kill levels flip rarely so rings fill between clears and held
   // levels last for a while
   function automatic req_type random_frame();
      req_type f;
      f.channel = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(CHANNELS - 1));
      if ($urandom_range(39) == 0) kill_level[f.channel] = !kill_level[f.channel];
      f.kill_button = kill_level[f.channel];
      f.dry_left = pick_sample();
      f.dry_right = pick_sample();
      f.arrival_left = pick_sample();
      f.arrival_right = pick_sample();
      f.gain_cv = pick_cv(4096);
      f.delay_cv = pick_cv(256);
      return f;
   endfunction

   // one request transfer, with random idle cycles ahead of it
   task automatic send_frame(input req_type frame);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= frame;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_mix.push_back(mix_frame(frame));
   endtask

   // stop sending and let every response come home
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_mix.size() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   // one register transfer, mirrored into the shadow knobs
   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx <= CSR_GAIN_THREE) gain_knob[idx] = value;
      else if (idx <= CSR_DELAY_THREE) delay_knob[idx - CSR_DELAY_ONE] = value[15:0];
      else if (idx == CSR_DELAY_SCALE) cv_scale = value[15:0];
      @(posedge clock);
   endtask

   // every knob rewritten, either short delays or one of the rails
   task automatic load_knobs(input knob_style_type style);
      logic [GAIN_BITS-1:0]  gain_val;
      logic [DELAY_BITS-1:0] delay_val;
      logic [DELAY_BITS-1:0] scale_val;
      for (int c = 0; c < CHANNELS; c++) begin
         case (style)
            KNOBS_FLOOR: begin
               gain_val = '0;
               delay_val = '0;
            end
            KNOBS_CEILING: begin
               gain_val = (c == 1) ? 17'h1FFFF : GAIN_UNITY;
               delay_val = 16'hFFFF;
            end
            default: begin
               // some gains above unity, delays short enough to reach stored data
               gain_val = 17'($urandom_range(70000));
               delay_val = 16'($urandom_range(100));
            end
         endcase
         write_reg(3'(CSR_GAIN_ONE + c), gain_val);
         write_reg(3'(CSR_DELAY_ONE + c), 17'(delay_val));
      end
      case (style)
         KNOBS_FLOOR: scale_val = '0;
         KNOBS_CEILING: scale_val = 16'hFFFF;
         default: scale_val = 16'($urandom_range(40));
      endcase
      write_reg(CSR_DELAY_SCALE, 17'(scale_val));
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      if (error_count < 50) $display("tb: mismatch %s: got %0d, want %0d", what, got, want);
      error_count++;
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // reset knobs: setback 32768 lands on never-written entries, dry passes
   task automatic test_idle_defaults();
      send_frame(make_frame(2'd0, 16'h7FFF, 16'h8000, 16'h1234, 16'hEDCB, 16'h7FFF, 16'd0, 1'b0));
      send_frame(make_frame(2'd1, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'd0, 1'b0));
      send_frame(make_frame(2'd2, 16'd0, 16'hFFFF, 16'h8000, 16'h7FFF, 16'd0, 16'd0, 1'b0));
   endtask

   // zero setback reads the pair just stored; sums clip at the rails
   task automatic test_zero_setback_saturation();
      settle();
      write_reg(CSR_DELAY_ONE, 17'd0);
      write_reg(CSR_GAIN_ONE, GAIN_UNITY);
      send_frame(make_frame(2'd0, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'd0, 16'd0, 1'b0));
      send_frame(make_frame(2'd0, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'd0, 16'd0, 1'b0));
      send_frame(make_frame(2'd0, 16'd100, 16'(-100), 16'(-300), 16'd300, 16'd0, 16'd0, 1'b0));
   endtask

   // knob above unity and cv pushing past either end of the gain range
   task automatic test_gain_clamp();
      settle();
      write_reg(CSR_GAIN_ONE, 17'h1FFFF);
      send_frame(make_frame(2'd0, 16'd0, 16'd0, 16'd1234, 16'(-1234), 16'd0, 16'd0, 1'b0));
      settle();
      write_reg(CSR_GAIN_ONE, 17'd0);
      send_frame(make_frame(2'd0, 16'd50, 16'(-50), 16'h7FFF, 16'h7FFF, 16'h8000, 16'd0, 1'b0));
      send_frame(make_frame(2'd0, 16'd0, 16'd0, 16'h8000, 16'h7FFF, 16'h7FFF, 16'd0, 1'b0));
   endtask

   // setback clamps at both ends, and cv rounding ties go away from zero
   task automatic test_delay_clamp();
      settle();
      write_reg(CSR_GAIN_ONE, GAIN_UNITY);
      write_reg(CSR_DELAY_ONE, 17'hFFFF);
      write_reg(CSR_DELAY_SCALE, 17'hFFFF);
      send_frame(make_frame(2'd0, 16'd7, 16'd9, 16'd1000, 16'd2000, 16'd0, 16'h7FFF, 1'b0));
      send_frame(make_frame(2'd0, 16'd7, 16'd9, 16'd3000, 16'd4000, 16'd0, 16'h8000, 1'b0));
      settle();
      write_reg(CSR_DELAY_ONE, 17'd5);
      write_reg(CSR_DELAY_SCALE, 17'd1);
      send_frame(make_frame(2'd0, 16'd0, 16'd0, 16'd11, 16'd22, 16'd0, 16'd1024, 1'b0));
      send_frame(make_frame(2'd0, 16'd0, 16'd0, 16'd33, 16'd44, 16'd0, 16'(-1024), 1'b0));
   endtask

   // rising kill zeroes, held kill passes audio, a second rise zeroes again
   task automatic test_kill_edges();
      settle();
      write_reg(CSR_DELAY_THREE, 17'd0);
      write_reg(CSR_GAIN_THREE, GAIN_UNITY);
      send_frame(make_frame(2'd2, 16'd1000, 16'd1000, 16'd2000, 16'd2000, 16'd0, 16'd0, 1'b1));
      send_frame(make_frame(2'd2, 16'd100, 16'd200, 16'd500, 16'd600, 16'd0, 16'd0, 1'b1));
      send_frame(make_frame(2'd2, 16'd100, 16'd200, 16'd700, 16'd800, 16'd0, 16'd0, 1'b0));
      send_frame(make_frame(2'd2, 16'd100, 16'd200, 16'd900, 16'd950, 16'd0, 16'd0, 1'b1));
   endtask

   // spare channel slot gives zeros and leaves every channel alone
   task automatic test_unused_channel();
      send_frame(make_frame(2'd3, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 1'b1));
      send_frame(make_frame(2'd3, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 1'b0));
      send_frame(make_frame(2'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd0, 16'd0, 1'b0));
   endtask

   // a write to the undecoded index changes nothing
   task automatic test_unknown_register();
      settle();
      write_reg(CSR_UNUSED, 17'h1FFFF);
      send_frame(make_frame(2'd0, 16'd5, 16'd6, 16'd7, 16'd8, 16'd0, 16'd0, 1'b0));
   endtask

   // one channel streamed with a swinging delay cv, so taps move back and
   // forth between empty entries and stored ones as the ring fills
   task automatic test_ring_fill();
      req_type f;
      settle();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      write_reg(CSR_GAIN_TWO, GAIN_UNITY);
      write_reg(CSR_DELAY_TWO, 17'd150);
      write_reg(CSR_DELAY_SCALE, 17'd2048);
      repeat (350) begin
         f = random_frame();
         f.channel = 2'd1;
         f.kill_button = 1'b0;
         f.delay_cv = 16'($urandom_range(300) - 150);
         send_frame(f);
      end
   endtask

   // receiver holds off for a long stretch while requests keep coming,
   // so the output register fills and req_stall rises
   task automatic test_output_backpressure();
      req_type f;
      settle();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_off_requests++;
      repeat (40) begin
         f = random_frame();
         send_frame(f);
      end
   endtask

   // random frames under four idling mixes, knobs reloaded between them
   task automatic test_random_traffic();
      req_type f;
      for (int phase = 0; phase < 4; phase++) begin
         settle();
         case (phase)
            0: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
               load_knobs(KNOBS_SHORT);
            end
            1: begin
               send_idle_pct = 84;
               recv_stall_pct = 0;
               load_knobs(KNOBS_FLOOR);
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct = 84;
               load_knobs(KNOBS_CEILING);
            end
            default: begin
               send_idle_pct = 25;
               recv_stall_pct = 25;
               load_knobs(KNOBS_SHORT);
            end
         endcase
         repeat (350) begin
            f = random_frame();
            send_frame(f);
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // receiver: checks each response transfer
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_mix.size() == 0) begin
            report_mismatch("response with nothing expected, left",
                            $signed(rsp_data.departure_left), 0);
         end else begin
            oldest_mix = expected_mix.pop_front();
            if (rsp_data.out_channel !== oldest_mix.out_channel)
               report_mismatch("out_channel", rsp_data.out_channel, oldest_mix.out_channel);
            if (rsp_data.departure_left !== oldest_mix.departure_left)
               report_mismatch("departure_left", $signed(rsp_data.departure_left),
                               $signed(oldest_mix.departure_left));
            if (rsp_data.departure_right !== oldest_mix.departure_right)
               report_mismatch("departure_right", $signed(rsp_data.departure_right),
                               $signed(oldest_mix.departure_right));
         end
      end
   end

   // receiver stall: random holds, plus the long hold-off counted here
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_off_served != hold_off_requests) begin
            hold_off_served = hold_off_requests;
            hold_off_left = HOLD_OFF_CYCLES;
         end
         if (hold_off_left > 0) begin
            hold_off_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   // watchdog: any transfer on any channel counts as progress
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: done, errors");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------
   initial begin
      // shadow knobs start at their reset values
      for (int c = 0; c < CHANNELS; c++) begin
         gain_knob[c] = GAIN_RESET;
         delay_knob[c] = DELAY_RESET;
      end
      cv_scale = SCALE_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_idle_defaults();
      test_zero_setback_saturation();
      test_gain_clamp();
      test_delay_clamp();
      test_kill_edges();
      test_unused_channel();
      test_unknown_register();
      test_ring_fill();
      test_output_backpressure();
      test_random_traffic();

      settle();
      if (error_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
